// File: sv/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants for the all-pairs shortest path unit.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int DIST_W = 12;
    localparam int WEIGHT_W = 8;
    localparam int CFG_W = 4;
    localparam int NODE_OUT_W = 3;
    localparam logic [DIST_W-1:0] NO_PATH = 12'hFFF;
    localparam int NODE_RESET = 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW_RD,
        ST_ROW_CAP,
        ST_PAIR,
        ST_EMIT_RD,
        ST_EMIT_CAP,
        ST_EMIT_HOLD
    } apsp_state_t;

endpackage

// File: sv/apsp_dist_ram.sv
// ----------------------------------------------------------------------------
// apsp_dist_ram
// Distance store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module apsp_dist_ram #(
    parameter int AW = 6,
    parameter int DW = 12
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: sv/all_pairs_shortest_path_unit.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_unit
// Floyd-Warshall over an adjacency matrix held in a dual-read distance RAM.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, node_count) sets the node count n,
//   clamped to 1..MAX_NODES; a write restarts any partial load. cfg_ready is
//   high only while loading, and input is stalled while cfg_valid is high.
//   Input items (in_valid/in_stall, edge_weight) carry the n*n adjacency
//   entries in row-major order, one per cycle; zero means no edge.
//   After the last entry the block relaxes every pair through every
//   intermediate node: per (k, i) ST_ROW_RD reads d[i][k], ST_ROW_CAP
//   captures it, then ST_PAIR streams the row through both RAM read ports
//   with the write-back in the cycle after each read.
//   Results (out_valid/out_stall, distance, from_node, to_node, last_result)
//   then follow in row-major order, each read, captured and held before the
//   next is read; a stall holds the current item and pauses the sweep.
//   Input is stalled from the last load item until the last result is taken.
//   Reset: n = min(8, MAX_NODES), load count cleared, no result pending.
//   The RAM is not cleared; every entry is written by a load before use.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_unit #(
    parameter int MAX_NODES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [apsp_pkg::CFG_W-1:0]        node_count,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [apsp_pkg::WEIGHT_W-1:0]     edge_weight,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [apsp_pkg::DIST_W-1:0]       distance,
    output logic [apsp_pkg::NODE_OUT_W-1:0]   from_node,
    output logic [apsp_pkg::NODE_OUT_W-1:0]   to_node,
    output logic                              last_result
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES * MAX_NODES);
    localparam int PW = IW + NW;
    localparam int TW = 2 * NW;
    localparam int DW = apsp_pkg::DIST_W;
    localparam int OW = apsp_pkg::NODE_OUT_W;
    localparam int N_RESET = (apsp_pkg::NODE_RESET > MAX_NODES) ?
                             MAX_NODES : apsp_pkg::NODE_RESET;

    apsp_pkg::apsp_state_t state_reg, state_next;

    logic [NW-1:0] n_reg;
    logic [AW-1:0] load_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic [DW-1:0] ik_reg;
    logic          pend_valid_reg;
    logic [AW-1:0] pend_addr_reg;
    logic          out_valid_reg;
    logic [DW-1:0] dist_reg;
    logic [OW-1:0] from_reg, to_reg;
    logic          last_reg;

    logic [NW-1:0] n_last;
    logic [TW-1:0] total;
    logic          load_done;
    logic          j_end, i_end, k_end;
    logic          in_acc, cfg_acc, out_acc;
    logic [PW-1:0] base_i, base_k;
    logic [AW-1:0] addr_ij, addr_ik, addr_kj;
    logic [DW:0]   sum;
    logic [DW-1:0] sum_sat;
    logic          relax_wr;
    logic [NW-1:0] n_cfg;
    logic [IW+OW-1:0] i_ext, j_ext;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr_a;
    logic [DW-1:0] rd_data_a, rd_data_b;

    assign n_last    = n_reg - NW'(1);
    assign total     = TW'(n_reg) * TW'(n_reg);
    assign load_done = (TW'(load_reg) + TW'(1)) == total;
    assign j_end     = NW'(j_reg) == n_last;
    assign i_end     = NW'(i_reg) == n_last;
    assign k_end     = NW'(k_reg) == n_last;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_acc   = out_valid_reg && !out_stall;

    assign base_i  = PW'(i_reg) * PW'(n_reg);
    assign base_k  = PW'(k_reg) * PW'(n_reg);
    assign addr_ij = AW'(base_i + PW'(j_reg));
    assign addr_ik = AW'(base_i + PW'(k_reg));
    assign addr_kj = AW'(base_k + PW'(j_reg));

    // d[i][k] and d[k][j] cannot shrink during round k (weights are
    // non-negative), so the write-back never races a read it affects.
    assign sum      = {1'b0, ik_reg} + {1'b0, rd_data_b};
    assign sum_sat  = (sum >= (DW+1)'(apsp_pkg::NO_PATH)) ? apsp_pkg::NO_PATH : sum[DW-1:0];
    assign relax_wr = pend_valid_reg && (sum_sat < rd_data_a);

    always_comb
    begin
        if (node_count == '0)
        begin
            n_cfg = NW'(1);
        end
        else if (int'(node_count) > MAX_NODES)
        begin
            n_cfg = NW'(MAX_NODES);
        end
        else
        begin
            n_cfg = NW'(node_count);
        end
    end

    always_comb
    begin
        priority if (in_acc)
        begin
            wr_en   = 1'b1;
            wr_addr = load_reg;
            wr_data = (edge_weight == '0) ? apsp_pkg::NO_PATH : DW'(edge_weight);
        end
        else
        begin
            wr_en   = relax_wr;
            wr_addr = pend_addr_reg;
            wr_data = sum_sat;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apsp_pkg::ST_LOAD:
            begin
                if (in_acc && load_done)
                begin
                    state_next = apsp_pkg::ST_ROW_RD;
                end
            end
            apsp_pkg::ST_ROW_RD:
            begin
                state_next = apsp_pkg::ST_ROW_CAP;
            end
            apsp_pkg::ST_ROW_CAP:
            begin
                state_next = apsp_pkg::ST_PAIR;
            end
            apsp_pkg::ST_PAIR:
            begin
                if (j_end)
                begin
                    state_next = (i_end && k_end) ? apsp_pkg::ST_EMIT_RD : apsp_pkg::ST_ROW_RD;
                end
            end
            apsp_pkg::ST_EMIT_RD:
            begin
                state_next = apsp_pkg::ST_EMIT_CAP;
            end
            apsp_pkg::ST_EMIT_CAP:
            begin
                state_next = apsp_pkg::ST_EMIT_HOLD;
            end
            apsp_pkg::ST_EMIT_HOLD:
            begin
                if (out_acc)
                begin
                    state_next = last_reg ? apsp_pkg::ST_LOAD : apsp_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = apsp_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cfg_ready = 1'b0;
        in_stall  = 1'b1;
        rd_addr_a = addr_ij;
        unique case (state_reg)
            apsp_pkg::ST_LOAD:
            begin
                cfg_ready = 1'b1;
                in_stall  = cfg_valid;
            end
            apsp_pkg::ST_ROW_RD:
            begin
                rd_addr_a = addr_ik;
            end
            default:
            begin
                rd_addr_a = addr_ij;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= apsp_pkg::ST_LOAD;
            n_reg          <= NW'(N_RESET);
            load_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= (state_reg == apsp_pkg::ST_PAIR);
            unique case (state_reg)
                apsp_pkg::ST_LOAD:
                begin
                    if (cfg_acc)
                    begin
                        n_reg    <= n_cfg;
                        load_reg <= '0;
                    end
                    else if (in_acc)
                    begin
                        load_reg <= load_done ? '0 : load_reg + AW'(1);
                        i_reg    <= '0;
                        j_reg    <= '0;
                        k_reg    <= '0;
                    end
                end
                apsp_pkg::ST_ROW_CAP:
                begin
                    j_reg <= '0;
                end
                apsp_pkg::ST_PAIR:
                begin
                    if (j_end)
                    begin
                        j_reg <= '0;
                        if (i_end)
                        begin
                            i_reg <= '0;
                            k_reg <= k_end ? '0 : k_reg + IW'(1);
                        end
                        else
                        begin
                            i_reg <= i_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                apsp_pkg::ST_EMIT_CAP:
                begin
                    out_valid_reg <= 1'b1;
                end
                apsp_pkg::ST_EMIT_HOLD:
                begin
                    if (out_acc)
                    begin
                        out_valid_reg <= 1'b0;
                        if (j_end)
                        begin
                            j_reg <= '0;
                            i_reg <= i_end ? '0 : i_reg + IW'(1);
                        end
                        else
                        begin
                            j_reg <= j_reg + IW'(1);
                        end
                    end
                end
                default:
                begin
                    load_reg <= load_reg;
                end
            endcase
        end
    end

    assign i_ext = {{OW{1'b0}}, i_reg};
    assign j_ext = {{OW{1'b0}}, j_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == apsp_pkg::ST_ROW_CAP)
        begin
            ik_reg <= rd_data_a;
        end
        if (state_reg == apsp_pkg::ST_PAIR)
        begin
            pend_addr_reg <= addr_ij;
        end
        if (state_reg == apsp_pkg::ST_EMIT_CAP)
        begin
            dist_reg <= rd_data_a;
            from_reg <= i_ext[OW-1:0];
            to_reg   <= j_ext[OW-1:0];
            last_reg <= i_end && j_end;
        end
    end

    apsp_dist_ram #(
        .AW (AW),
        .DW (DW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (addr_kj),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign out_valid   = out_valid_reg;
    assign distance    = dist_reg;
    assign from_node   = from_reg;
    assign to_node     = to_reg;
    assign last_result = last_reg;

endmodule

// File: sv/apsp_checker.sv
// ----------------------------------------------------------------------------
// apsp_checker
// Port-level checks for the all-pairs shortest path unit.
// ----------------------------------------------------------------------------
module apsp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [apsp_pkg::DIST_W-1:0]       distance,
    input logic [apsp_pkg::NODE_OUT_W-1:0]   from_node,
    input logic [apsp_pkg::NODE_OUT_W-1:0]   to_node,
    input logic                              last_result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance) && $stable(from_node)
            && $stable(to_node) && $stable(last_result))
        else $error("stalled result item changed");

    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall && !cfg_ready)
        else $error("input or config open while results pending");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> in_stall)
        else $error("input taken alongside config write");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_result |=> !out_valid && cfg_ready)
        else $error("result burst did not end after last item");

endmodule

bind all_pairs_shortest_path_unit apsp_checker u_apsp_checker (.*);
